// ===== src/tsppu_pkg.sv =====
// Shared types, codes and constants of the tile and sprite scanline picture unit.
`default_nettype none
package tsppu_pkg;

	localparam int VRAM_BYTES       = 8192;
	localparam int VRAM_AW          = $clog2(VRAM_BYTES);
	localparam int OAM_BYTES        = 160;
	localparam int OAM_AW           = $clog2(OAM_BYTES);
	localparam int OAM_SPRITES      = 40;
	localparam int SPRITES_PER_LINE = 10;
	localparam int SPR_CNT_W        = $clog2(SPRITES_PER_LINE + 1);
	localparam int SCREEN_WIDTH     = 160;
	localparam int LINE_DOTS        = 456;
	localparam int LAST_LINE        = 153;
	localparam int VBLANK_LINE      = 144;
	localparam int SCAN_DOTS        = 80;

	localparam logic [12:0] MAP_LO      = 13'h1800;
	localparam logic [12:0] MAP_HI      = 13'h1C00;
	localparam logic [12:0] TILE_SHIFT  = 13'h1000;

	// Control register bits.
	localparam int LCDC_ENABLE  = 7;
	localparam int LCDC_WIN_MAP = 6;
	localparam int LCDC_WIN_ON  = 5;
	localparam int LCDC_UNSIGN  = 4;
	localparam int LCDC_BG_MAP  = 3;
	localparam int LCDC_TALL    = 2;
	localparam int LCDC_OBJ_ON  = 1;

	// Sprite attribute bits.
	localparam int ATTR_BEHIND = 7;
	localparam int ATTR_YFLIP  = 6;
	localparam int ATTR_XFLIP  = 5;
	localparam int ATTR_PAL    = 4;

	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_VRAM = 2'd1;
	localparam logic [1:0] ACT_OAM  = 2'd2;

	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_SCAN   = 2'd2;
	localparam logic [1:0] MODE_DRAW   = 2'd3;

	localparam logic [2:0] CFG_LCDC   = 3'd0;
	localparam logic [2:0] CFG_SCROLL = 3'd1;
	localparam logic [2:0] CFG_WINPOS = 3'd2;
	localparam logic [2:0] CFG_BGP    = 3'd3;
	localparam logic [2:0] CFG_OBP    = 3'd4;
	localparam logic [2:0] CFG_LYC    = 3'd5;
	localparam logic [2:0] CFG_STATEN = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BEGIN,
		ST_SCAN,
		ST_SCAN_EVAL,
		ST_SPR_CHK,
		ST_SPR_LO,
		ST_SPR_HI,
		ST_FETCH,
		ST_FETCH_WB,
		ST_DRAW,
		ST_FINISH
	} state_t;

	// Raw attribute bytes of one sprite as held in the line list.
	typedef struct packed {
		logic [7:0] y;
		logic [7:0] x;
		logic [7:0] tile;
		logic [7:0] attr;
	} spr_entry_t;

	typedef struct packed {
		logic clear;
		logic insert;
		logic mark;
	} spr_ctl_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
		logic merge;
	} fifo_ctl_t;

endpackage
`default_nettype wire

// ===== src/tsppu_ram.sv =====
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module tsppu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== src/tsppu_sprite_list.sv =====
// Per-line sprite list kept sorted by x, with fetched marks and the draw-column match.
`default_nettype none
module tsppu_sprite_list (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tsppu_pkg::spr_ctl_t   ctl,
	input  wire tsppu_pkg::spr_entry_t new_entry,
	input  wire logic [7:0]            draw_column,
	output logic                       hit,
	output tsppu_pkg::spr_entry_t      hit_entry
);

	localparam int N = tsppu_pkg::SPRITES_PER_LINE;

	tsppu_pkg::spr_entry_t        ent_q [N];
	logic [tsppu_pkg::SPR_CNT_W-1:0] cnt_q;
	logic [N-1:0]                 done_q;
	logic [N-1:0]                 le;
	logic [N-1:0]                 match;
	logic [N-1:0]                 first;
	logic [8:0]                   col8;

	assign col8 = {1'b0, draw_column} + 9'd8;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			le[i]    = (tsppu_pkg::SPR_CNT_W'(i) < cnt_q) && (ent_q[i].x <= new_entry.x);
			match[i] = (tsppu_pkg::SPR_CNT_W'(i) < cnt_q) && !done_q[i]
				&& ({1'b0, ent_q[i].x} == col8);
		end
	end

	// Lowest index wins, as the list is walked in order.
	always_comb begin
		logic seen;
		seen      = 1'b0;
		hit_entry = '0;
		for (int i = 0; i < N; i++) begin
			first[i] = match[i] && !seen;
			if (first[i]) begin
				hit_entry = ent_q[i];
			end
			seen = seen | match[i];
		end
		hit = seen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= '0;
		end else if (ctl.clear) begin
			cnt_q  <= '0;
			done_q <= '0;
		end else begin
			if (ctl.insert && cnt_q < tsppu_pkg::SPR_CNT_W'(N)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ctl.mark) begin
				done_q <= done_q | first;
			end
		end
	end

	// Stable insert: the new sprite goes after every entry with x not above its own.
	always_ff @(posedge clk) begin
		if (ctl.insert && !ctl.clear && cnt_q < tsppu_pkg::SPR_CNT_W'(N)) begin
			if (!le[0]) begin
				ent_q[0] <= new_entry;
			end
			for (int i = 1; i < N; i++) begin
				if (!le[i]) begin
					ent_q[i] <= le[i-1] ? new_entry : ent_q[i-1];
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/tsppu_fifos.sv =====
// Background and sprite pixel FIFOs with tile push, sprite merge and pixel pop.
`default_nettype none
module tsppu_fifos (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tsppu_pkg::fifo_ctl_t ctl,
	input  wire logic [7:0]           push_lo,
	input  wire logic [7:0]           push_hi,
	input  wire logic [7:0]           mrg_lo,
	input  wire logic [7:0]           mrg_hi,
	input  wire logic [7:0]           mrg_attr,
	output logic [1:0]                bg_head,
	output logic [4:0]                bg_cnt,
	output logic [3:0]                obj_head,
	output logic [3:0]                obj_cnt
);

	logic [1:0] bg_q  [16];
	logic [3:0] obj_q [8];
	logic [4:0] bg_cnt_q;
	logic [3:0] obj_cnt_q;
	logic [3:0] mrg_px [8];

	assign bg_head  = bg_q[0];
	assign bg_cnt   = bg_cnt_q;
	assign obj_head = obj_q[0];
	assign obj_cnt  = obj_cnt_q;

	always_comb begin
		logic [2:0] b;
		b = '0;
		for (int i = 0; i < 8; i++) begin
			b = mrg_attr[tsppu_pkg::ATTR_XFLIP] ? 3'(i) : 3'(7 - i);
			mrg_px[i] = {mrg_attr[tsppu_pkg::ATTR_BEHIND], mrg_attr[tsppu_pkg::ATTR_PAL],
				mrg_hi[b], mrg_lo[b]};
			// An opaque pixel already queued keeps its place.
			if ((4'(i) < obj_cnt_q) && (obj_q[i][1:0] != 2'd0)) begin
				mrg_px[i] = obj_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_cnt_q  <= '0;
			obj_cnt_q <= '0;
		end else if (ctl.clear) begin
			bg_cnt_q  <= '0;
			obj_cnt_q <= '0;
		end else begin
			if (ctl.push) begin
				bg_cnt_q <= bg_cnt_q + 5'd8;
			end
			if (ctl.merge) begin
				obj_cnt_q <= 4'd8;
			end
			if (ctl.pop) begin
				if (bg_cnt_q != 5'd0) begin
					bg_cnt_q <= bg_cnt_q - 1'b1;
				end
				if (obj_cnt_q != 4'd0) begin
					obj_cnt_q <= obj_cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [4:0] k;
		k = '0;
		if (ctl.push) begin
			for (int j = 0; j < 16; j++) begin
				k = 5'(j) - bg_cnt_q;
				if ((5'(j) >= bg_cnt_q) && (k < 5'd8)) begin
					bg_q[j] <= {push_hi[3'd7 - k[2:0]], push_lo[3'd7 - k[2:0]]};
				end
			end
		end else if (ctl.pop) begin
			for (int j = 0; j < 15; j++) begin
				bg_q[j] <= bg_q[j+1];
			end
		end
		if (ctl.merge) begin
			for (int i = 0; i < 8; i++) begin
				obj_q[i] <= mrg_px[i];
			end
		end else if (ctl.pop && obj_cnt_q != 4'd0) begin
			for (int i = 0; i < 7; i++) begin
				obj_q[i] <= obj_q[i+1];
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/tile_sprite_scanline_ppu.sv =====
// Top level: dot sequencer, tile fetcher, pixel mixer, timing and configuration registers.
`default_nettype none
// Each input word is a dot tick or a byte write into video RAM or attribute RAM,
// and each produces exactly one output word carrying the pixel (if any), the mode,
// the coincidence flag and the interrupt pulses. One word is worked on at a time.
// Writes, ignored actions and ticks while the display is off go straight to the
// finish state. An even attribute scan dot with sprites on makes four reads of the
// single attribute RAM port, and a drawing dot reads both bytes of every sprite
// row fetched on that dot, then any tile fetcher byte, through the single read
// port of video RAM. The final state of a word holds for as long as the previous
// result still waits in the output register, and a new word is taken while that
// result waits.
module tile_sprite_scanline_ppu (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [1:0] action, [14:2] address, [22:15] data, [23] zero
	input  wire logic [23:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] pixel_valid, [8:1] pixel_x, [16:9] pixel_y, [18:17] shade, [20:19] lcd_mode,
	// [21] coincidence, [22] vblank_irq, [23] stat_irq, [24] frame_done, [31:25] zero
	output logic [31:0]      m_axis_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	tsppu_pkg::state_t state_q, state_nx;

	logic [7:0]  lcdc_q, bgp_q, lyc_q;
	logic [15:0] scroll_q, winpos_q, obp_q;
	logic [3:0]  staten_q;
	logic [8:0]  dot_q;
	logic [7:0]  line_q;
	logic [1:0]  mode_q;
	logic        mode_vld_q;
	logic [1:0]  fstep_q;
	logic        fphase_q;
	logic [7:0]  fcol_q, ltile_q, llo_q, lhi_q;
	logic [2:0]  lrow_q;
	logic [7:0]  dcol_q, lscx_q, wline_q;
	logic [2:0]  disc_q;
	logic        wact_q, coin_q;
	logic        tick_q, pv_q, vb_q, st_q;
	logic [7:0]  px_q;
	logic [1:0]  shade_q;
	logic [2:0]  scan_cnt_q;
	logic [7:0]  scan_y_q, scan_x_q, scan_tile_q, scan_attr_q, spr_lo_q;
	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic [1:0]  in_action;
	logic [12:0] in_address;
	logic [7:0]  in_data;
	logic        accept, out_free;

	logic [12:0] vram_raddr;
	logic [7:0]  vram_rdata;
	logic [7:0]  oam_raddr;
	logic [7:0]  oam_rdata;
	logic        vram_we, oam_we;

	tsppu_pkg::spr_ctl_t   spr_ctl;
	tsppu_pkg::spr_entry_t scan_entry, hit_entry;
	logic                  spr_hit;
	tsppu_pkg::fifo_ctl_t  fifo_ctl;
	logic [1:0]            bg_head;
	logic [4:0]            bg_cnt;
	logic [3:0]            obj_head, obj_cnt;

	assign in_action  = s_axis_tdata[1:0];
	assign in_address = s_axis_tdata[14:2];
	assign in_data    = s_axis_tdata[22:15];
	assign s_axis_tready = (state_q == tsppu_pkg::ST_IDLE);
	assign accept     = s_axis_tvalid && s_axis_tready;
	assign out_free   = !out_valid_q || m_axis_tready;
	assign cfg_ready  = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign vram_we = accept && (in_action == tsppu_pkg::ACT_VRAM);
	assign oam_we  = accept && (in_action == tsppu_pkg::ACT_OAM)
		&& (in_address < 13'(tsppu_pkg::OAM_BYTES));

	tsppu_ram #(.WIDTH(8), .DEPTH(tsppu_pkg::VRAM_BYTES)) u_vram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (in_address),
		.wdata (in_data),
		.raddr (vram_raddr),
		.rdata (vram_rdata)
	);

	tsppu_ram #(.WIDTH(8), .DEPTH(tsppu_pkg::OAM_BYTES)) u_oam (
		.clk   (clk),
		.we    (oam_we),
		.waddr (in_address[7:0]),
		.wdata (in_data),
		.raddr (oam_raddr),
		.rdata (oam_rdata)
	);

	assign scan_entry = '{y: scan_y_q, x: scan_x_q, tile: scan_tile_q, attr: scan_attr_q};

	tsppu_sprite_list u_list (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (spr_ctl),
		.new_entry   (scan_entry),
		.draw_column (dcol_q),
		.hit         (spr_hit),
		.hit_entry   (hit_entry)
	);

	tsppu_fifos u_fifos (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (fifo_ctl),
		.push_lo  (llo_q),
		.push_hi  (lhi_q),
		.mrg_lo   (spr_lo_q),
		.mrg_hi   (vram_rdata),
		.mrg_attr (hit_entry.attr),
		.bg_head  (bg_head),
		.bg_cnt   (bg_cnt),
		.obj_head (obj_head),
		.obj_cnt  (obj_cnt)
	);

	// Line position and sprite geometry.
	logic        tall, visible, dot0, scan_ok, begin_scan_dot;
	logic [8:0]  ly16;
	logic        scan_hit;
	logic [3:0]  srow, srow_f;
	logic [7:0]  stile;
	logic [12:0] spr_addr;

	assign tall    = lcdc_q[tsppu_pkg::LCDC_TALL];
	assign visible = line_q < 8'(tsppu_pkg::VBLANK_LINE);
	assign dot0    = (dot_q == 9'd0);
	assign begin_scan_dot = dot_q < 9'(tsppu_pkg::SCAN_DOTS);
	assign scan_ok = !dot_q[0] && (dot_q[8:1] < 8'(tsppu_pkg::OAM_SPRITES))
		&& lcdc_q[tsppu_pkg::LCDC_OBJ_ON];
	assign ly16    = {1'b0, line_q} + 9'd16;
	assign scan_hit = (ly16 >= {1'b0, scan_y_q})
		&& (ly16 < ({1'b0, scan_y_q} + (tall ? 9'd16 : 9'd8)));

	always_comb begin
		logic [8:0] d;
		d    = ly16 - {1'b0, hit_entry.y};
		srow = d[3:0];
		srow_f = srow;
		if (hit_entry.attr[tsppu_pkg::ATTR_YFLIP]) begin
			srow_f = tall ? ~srow : (4'd7 - srow);
		end
		stile    = tall ? {hit_entry.tile[7:1], 1'b0} : hit_entry.tile;
		spr_addr = {1'b0, stile, 4'b0000} + {8'b0, srow_f, 1'b0};
	end

	// Tile fetcher addresses.
	logic [7:0]  wx, wy, sx, sy;
	logic [8:0]  fc14, wcol;
	logic        reach, wact_nx, use_win;
	logic [12:0] map_addr, tdo;
	logic [2:0]  map_row;

	assign wx   = winpos_q[7:0];
	assign wy   = winpos_q[15:8];
	assign fc14 = {1'b0, fcol_q} + 9'd14;
	assign reach = fc14 >= {1'b0, wx};
	assign wact_nx = wact_q || (lcdc_q[tsppu_pkg::LCDC_WIN_ON] && (line_q >= wy) && reach);
	assign use_win = wact_nx && reach;
	assign wcol = fc14 - {1'b0, wx};
	assign sx   = lscx_q + fcol_q;
	assign sy   = scroll_q[15:8] + line_q;

	always_comb begin
		if (use_win) begin
			map_addr = (lcdc_q[tsppu_pkg::LCDC_WIN_MAP] ? tsppu_pkg::MAP_HI : tsppu_pkg::MAP_LO)
				+ {3'b0, wline_q[7:3], 5'b0} + {7'b0, wcol[8:3]};
			map_row = wline_q[2:0];
		end else begin
			map_addr = (lcdc_q[tsppu_pkg::LCDC_BG_MAP] ? tsppu_pkg::MAP_HI : tsppu_pkg::MAP_LO)
				+ {3'b0, sy[7:3], 5'b0} + {8'b0, sx[7:3]};
			map_row = sy[2:0];
		end
		tdo = {1'b0, ltile_q, 4'b0000} + {9'b0, lrow_q, 1'b0};
		if (!lcdc_q[tsppu_pkg::LCDC_UNSIGN] && !ltile_q[7]) begin
			tdo = tdo + tsppu_pkg::TILE_SHIFT;
		end
	end

	// Pixel mixing.
	logic       discard, use_obj;
	logic [1:0] bg_shade, obj_shade, mix_shade;
	logic [7:0] obj_pal;

	assign discard   = disc_q < lscx_q[2:0];
	assign bg_shade  = bgp_q[{bg_head, 1'b0} +: 2];
	assign obj_pal   = obj_head[2] ? obp_q[15:8] : obp_q[7:0];
	assign obj_shade = obj_pal[{obj_head[1:0], 1'b0} +: 2];
	assign use_obj   = (obj_cnt != 4'd0) && (obj_head[1:0] != 2'd0)
		&& (!obj_head[3] || bg_head == 2'd0);
	assign mix_shade = use_obj ? obj_shade : bg_shade;

	// Mode changes requested when a dot starts.
	logic       mode_set, mode_pulse;
	logic [1:0] mode_new;

	always_comb begin
		mode_set = 1'b0;
		mode_new = tsppu_pkg::MODE_HBLANK;
		if (!visible) begin
			if (dot0) begin
				mode_set = 1'b1;
				mode_new = tsppu_pkg::MODE_VBLANK;
			end
		end else if (begin_scan_dot) begin
			if (dot0) begin
				mode_set = 1'b1;
				mode_new = tsppu_pkg::MODE_SCAN;
			end
		end else if (dot_q == 9'(tsppu_pkg::SCAN_DOTS)) begin
			mode_set = 1'b1;
			mode_new = tsppu_pkg::MODE_DRAW;
		end else if (dcol_q == 8'(tsppu_pkg::SCREEN_WIDTH)) begin
			mode_set = 1'b1;
			mode_new = tsppu_pkg::MODE_HBLANK;
		end
		case (mode_new)
			tsppu_pkg::MODE_HBLANK: mode_pulse = staten_q[0];
			tsppu_pkg::MODE_VBLANK: mode_pulse = staten_q[1];
			tsppu_pkg::MODE_SCAN:   mode_pulse = staten_q[2];
			default:                mode_pulse = 1'b0;
		endcase
	end

	// End of dot: line advance and coincidence.
	logic [8:0] dot_inc;
	logic       eol, wrap, coin_now, coin_pulse;
	logic [7:0] line_nx;
	logic [31:0] out_word;

	assign dot_inc = dot_q + 9'd1;
	assign eol     = tick_q && (dot_inc >= 9'(tsppu_pkg::LINE_DOTS));
	assign wrap    = line_q >= 8'(tsppu_pkg::LAST_LINE);
	assign line_nx = eol ? (wrap ? 8'd0 : line_q + 8'd1) : line_q;
	assign coin_now   = (line_nx == lyc_q);
	assign coin_pulse = eol && !coin_q && coin_now && staten_q[3];

	assign out_word = {7'b0, eol && wrap, st_q || coin_pulse, vb_q,
		eol ? coin_now : coin_q, mode_vld_q ? mode_q : 2'd0,
		pv_q ? shade_q : 2'd0, pv_q ? line_nx : 8'd0, pv_q ? px_q : 8'd0, pv_q};

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			tsppu_pkg::ST_IDLE: begin
				if (accept) begin
					state_nx = ((in_action == tsppu_pkg::ACT_TICK)
						&& lcdc_q[tsppu_pkg::LCDC_ENABLE])
						? tsppu_pkg::ST_BEGIN : tsppu_pkg::ST_FINISH;
				end
			end
			tsppu_pkg::ST_BEGIN: begin
				if (!visible) begin
					state_nx = tsppu_pkg::ST_FINISH;
				end else if (begin_scan_dot) begin
					state_nx = scan_ok ? tsppu_pkg::ST_SCAN : tsppu_pkg::ST_FINISH;
				end else if (dot_q == 9'(tsppu_pkg::SCAN_DOTS)) begin
					state_nx = tsppu_pkg::ST_FINISH;
				end else if (dcol_q < 8'(tsppu_pkg::SCREEN_WIDTH)) begin
					state_nx = tsppu_pkg::ST_SPR_CHK;
				end else begin
					state_nx = tsppu_pkg::ST_FINISH;
				end
			end
			tsppu_pkg::ST_SCAN: begin
				if (scan_cnt_q == 3'd4) begin
					state_nx = tsppu_pkg::ST_SCAN_EVAL;
				end
			end
			tsppu_pkg::ST_SCAN_EVAL: state_nx = tsppu_pkg::ST_FINISH;
			tsppu_pkg::ST_SPR_CHK: begin
				state_nx = (lcdc_q[tsppu_pkg::LCDC_OBJ_ON] && spr_hit)
					? tsppu_pkg::ST_SPR_LO : tsppu_pkg::ST_FETCH;
			end
			tsppu_pkg::ST_SPR_LO: state_nx = tsppu_pkg::ST_SPR_HI;
			tsppu_pkg::ST_SPR_HI: state_nx = tsppu_pkg::ST_SPR_CHK;
			tsppu_pkg::ST_FETCH: begin
				state_nx = (fphase_q && fstep_q != 2'd3)
					? tsppu_pkg::ST_FETCH_WB : tsppu_pkg::ST_DRAW;
			end
			tsppu_pkg::ST_FETCH_WB: state_nx = tsppu_pkg::ST_DRAW;
			tsppu_pkg::ST_DRAW:     state_nx = tsppu_pkg::ST_FINISH;
			tsppu_pkg::ST_FINISH: begin
				if (out_free) begin
					state_nx = tsppu_pkg::ST_IDLE;
				end
			end
			default: state_nx = tsppu_pkg::ST_IDLE;
		endcase
	end

	// Memory addresses and submodule controls.
	always_comb begin
		vram_raddr = tdo;
		oam_raddr  = {dot_q[6:1], scan_cnt_q[1:0]};
		spr_ctl    = '0;
		fifo_ctl   = '0;
		case (state_q)
			tsppu_pkg::ST_BEGIN: begin
				spr_ctl.clear  = visible && dot0;
				fifo_ctl.clear = visible && dot0;
			end
			tsppu_pkg::ST_SCAN_EVAL: spr_ctl.insert = scan_hit;
			tsppu_pkg::ST_SPR_CHK:   vram_raddr = spr_addr;
			tsppu_pkg::ST_SPR_LO:    vram_raddr = spr_addr + 13'd1;
			tsppu_pkg::ST_SPR_HI: begin
				spr_ctl.mark   = 1'b1;
				fifo_ctl.merge = 1'b1;
			end
			tsppu_pkg::ST_FETCH: begin
				case (fstep_q)
					2'd0:    vram_raddr = map_addr;
					2'd1:    vram_raddr = tdo;
					2'd2:    vram_raddr = tdo + 13'd1;
					default: fifo_ctl.push = fphase_q && (bg_cnt <= 5'd8);
				endcase
			end
			tsppu_pkg::ST_DRAW: fifo_ctl.pop = (bg_cnt != 5'd0);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsppu_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcdc_q <= 8'h91;
			scroll_q <= '0;
			winpos_q <= '0;
			bgp_q <= 8'hFC;
			obp_q <= '0;
			lyc_q <= '0;
			staten_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tsppu_pkg::CFG_LCDC:   lcdc_q   <= cfg_data[7:0];
				tsppu_pkg::CFG_SCROLL: scroll_q <= cfg_data;
				tsppu_pkg::CFG_WINPOS: winpos_q <= cfg_data;
				tsppu_pkg::CFG_BGP:    bgp_q    <= cfg_data[7:0];
				tsppu_pkg::CFG_OBP:    obp_q    <= cfg_data;
				tsppu_pkg::CFG_LYC:    lyc_q    <= cfg_data[7:0];
				tsppu_pkg::CFG_STATEN: staten_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			line_q <= '0;
			mode_q <= '0;
			mode_vld_q <= 1'b0;
			fstep_q <= '0;
			fphase_q <= 1'b0;
			fcol_q <= '0;
			ltile_q <= '0;
			lrow_q <= '0;
			llo_q <= '0;
			lhi_q <= '0;
			dcol_q <= '0;
			lscx_q <= '0;
			disc_q <= '0;
			wline_q <= '0;
			wact_q <= 1'b0;
			coin_q <= 1'b0;
			tick_q <= 1'b0;
			pv_q <= 1'b0;
			vb_q <= 1'b0;
			st_q <= 1'b0;
			px_q <= '0;
			shade_q <= '0;
			scan_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == tsppu_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				tsppu_pkg::ST_IDLE: begin
					if (accept) begin
						tick_q <= (in_action == tsppu_pkg::ACT_TICK)
							&& lcdc_q[tsppu_pkg::LCDC_ENABLE];
						pv_q <= 1'b0;
						vb_q <= 1'b0;
						st_q <= 1'b0;
					end
				end
				tsppu_pkg::ST_BEGIN: begin
					if (!visible && dot0 && line_q == 8'(tsppu_pkg::VBLANK_LINE)) begin
						vb_q <= 1'b1;
					end
					if (visible && dot0) begin
						fstep_q <= '0;
						fphase_q <= 1'b0;
						fcol_q <= '0;
						dcol_q <= '0;
						lscx_q <= scroll_q[7:0];
						disc_q <= '0;
					end
					if (mode_set && (!mode_vld_q || mode_q != mode_new)) begin
						mode_q <= mode_new;
						mode_vld_q <= 1'b1;
						if (mode_pulse) begin
							st_q <= 1'b1;
						end
					end
					if (visible && !begin_scan_dot && dot_q != 9'(tsppu_pkg::SCAN_DOTS)
						&& dcol_q == 8'(tsppu_pkg::SCREEN_WIDTH)) begin
						dcol_q <= dcol_q + 8'd1;
					end
					scan_cnt_q <= '0;
				end
				tsppu_pkg::ST_SCAN: scan_cnt_q <= scan_cnt_q + 3'd1;
				tsppu_pkg::ST_FETCH: begin
					fphase_q <= !fphase_q;
					if (fphase_q) begin
						case (fstep_q)
							2'd0: begin
								wact_q <= wact_nx;
								lrow_q <= map_row;
							end
							2'd3: begin
								if (bg_cnt <= 5'd8) begin
									fcol_q <= fcol_q + 8'd8;
									fstep_q <= 2'd0;
								end
							end
							default: ;
						endcase
					end
				end
				tsppu_pkg::ST_FETCH_WB: begin
					case (fstep_q)
						2'd0:    ltile_q <= vram_rdata;
						2'd1:    llo_q <= vram_rdata;
						default: lhi_q <= vram_rdata;
					endcase
					fstep_q <= fstep_q + 2'd1;
				end
				tsppu_pkg::ST_DRAW: begin
					if (bg_cnt != 5'd0) begin
						if (discard) begin
							disc_q <= disc_q + 3'd1;
						end else begin
							pv_q <= 1'b1;
							px_q <= dcol_q;
							shade_q <= mix_shade;
							dcol_q <= dcol_q + 8'd1;
							if (wact_q && dcol_q == 8'(tsppu_pkg::SCREEN_WIDTH - 1)) begin
								wline_q <= wline_q + 8'd1;
							end
						end
					end
				end
				tsppu_pkg::ST_FINISH: begin
					if (out_free) begin
						if (tick_q) begin
							dot_q <= eol ? 9'd0 : dot_inc;
							line_q <= line_nx;
							if (eol) begin
								coin_q <= coin_now;
								if (wrap) begin
									wact_q <= 1'b0;
									wline_q <= '0;
								end
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Payload captures.
	always_ff @(posedge clk) begin
		if (state_q == tsppu_pkg::ST_SCAN) begin
			case (scan_cnt_q)
				3'd1:    scan_y_q <= oam_rdata;
				3'd2:    scan_x_q <= oam_rdata;
				3'd3:    scan_tile_q <= oam_rdata;
				3'd4:    scan_attr_q <= oam_rdata;
				default: ;
			endcase
		end
		if (state_q == tsppu_pkg::ST_SPR_LO) begin
			spr_lo_q <= vram_rdata;
		end
		if (state_q == tsppu_pkg::ST_FINISH && out_free) begin
			out_data_q <= out_word;
		end
	end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the scanline picture unit: directed rows and random phases.
module testbench;
	import tsppu_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int MODE_UNSET = 4;
	localparam int IDLE_PCT = 34;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_AT = 9000;
	localparam int HOLD_LEN = 400;
	localparam int PHASE_ITEMS = 370;

	// Result word fields from the top bit down, so that bit 0 is pixel_valid.
	typedef struct packed {
		logic       frame;
		logic       stat;
		logic       vblank;
		logic       coinc;
		logic [1:0] mode;
		logic [1:0] shade;
		logic [7:0] y;
		logic [7:0] x;
		logic       valid;
	} ppu_word_t;

	typedef struct {
		bit          is_cfg;
		logic [2:0]  sel;
		logic [12:0] adr;
		logic [15:0] val;
		bit          known;
		logic [24:0] want;
	} dir_row_t;

	typedef struct {
		int         y;
		int         x;
		logic [7:0] tile;
		logic [7:0] attr;
	} line_sprite_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	ppu_word_t pixel_q[$];
	dir_row_t rows[$];
	int errors = 0;
	int words_out = 0;
	int hold_left = 0;
	bit held = 0;
	bit calm = 0;
	int stall_cycles = 0;

	// Predictor state.
	logic [7:0] lcdc, bgp, lyc;
	logic [3:0] sten;
	logic [15:0] scroll, winpos, obp;
	logic [7:0] vram_m[VRAM_BYTES];
	logic [7:0] oam_m[OAM_BYTES];
	int dots, lines, mode_m, nspr, fstep, fphase, fcol;
	int l_tile, l_row, l_lo, l_hi, bgn, objn, dcol, lsx, ndisc, wline;
	logic [9:0] fetched;
	line_sprite_t sprs[SPRITES_PER_LINE];
	int bgq[16];
	int objq[8];
	bit win_on, coinc, p_vb, p_st, p_fr;

	tile_sprite_scanline_ppu dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic void model_reset();
		lcdc = 8'h91; scroll = 0; winpos = 0; bgp = 8'hFC; obp = 0; lyc = 0; sten = 0;
		dots = 0; lines = 0; mode_m = MODE_UNSET; nspr = 0; fetched = 0;
		fstep = 0; fphase = 0; fcol = 0; l_tile = 0; l_row = 0; l_lo = 0; l_hi = 0;
		bgn = 0; objn = 0; dcol = 0; lsx = 0; ndisc = 0; wline = 0;
		win_on = 0; coinc = 0;
	endfunction

	function automatic void model_config(logic [2:0] idx, logic [15:0] v);
		case (idx)
			CFG_LCDC:   lcdc = v[7:0];
			CFG_SCROLL: scroll = v;
			CFG_WINPOS: winpos = v;
			CFG_BGP:    bgp = v[7:0];
			CFG_OBP:    obp = v;
			CFG_LYC:    lyc = v[7:0];
			CFG_STATEN: sten = v[3:0];
			default: ;
		endcase
	endfunction

	function automatic int vram_at(int a);
		return int'(vram_m[a & (VRAM_BYTES - 1)]);
	endfunction

	function automatic void set_mode(int m);
		if (m == mode_m)
			return;
		mode_m = m;
		if ((m == 0 && sten[0]) || (m == 1 && sten[1]) || (m == 2 && sten[2]))
			p_st = 1;
	endfunction

	function automatic void next_line();
		bit now;
		dots = 0;
		lines++;
		if (lines > LAST_LINE) begin
			lines = 0;
			p_fr = 1;
			win_on = 0;
			wline = 0;
		end
		now = (lines == int'(lyc));
		if (!coinc && now && sten[3])
			p_st = 1;
		coinc = now;
	endfunction

	function automatic void scan_sprite();
		int idx, base, h, sy;
		if (dots & 1)
			return;
		idx = dots / 2;
		if (idx >= OAM_SPRITES || !lcdc[LCDC_OBJ_ON])
			return;
		h = lcdc[LCDC_TALL] ? 16 : 8;
		base = idx * 4;
		sy = int'(oam_m[base]) - 16;
		if (lines >= sy && lines < sy + h && nspr < SPRITES_PER_LINE) begin
			sprs[nspr].y = sy;
			sprs[nspr].x = int'(oam_m[base + 1]) - 8;
			sprs[nspr].tile = oam_m[base + 2];
			sprs[nspr].attr = oam_m[base + 3];
			nspr++;
		end
	endfunction

	// Stable insertion sort on x, so sprites with equal x keep attribute RAM order.
	function automatic void sort_by_x();
		line_sprite_t t;
		int j;
		for (int i = 1; i < nspr; i++) begin
			t = sprs[i];
			j = i;
			while (j > 0 && sprs[j - 1].x > t.x) begin
				sprs[j] = sprs[j - 1];
				j--;
			end
			sprs[j] = t;
		end
	endfunction

	function automatic void load_sprite_row(int i);
		int h, tile, row, adr, lo, hi, bitn, px, old;
		h = lcdc[LCDC_TALL] ? 16 : 8;
		tile = int'(sprs[i].tile);
		if (h == 16)
			tile &= 'hFE;
		row = lines - sprs[i].y;
		if (sprs[i].attr[ATTR_YFLIP])
			row = (h - 1) - row;
		row &= 15;
		adr = tile * 16 + row * 2;
		lo = vram_at(adr);
		hi = vram_at(adr + 1);
		for (int k = 0; k < 8; k++) begin
			bitn = sprs[i].attr[ATTR_XFLIP] ? k : 7 - k;
			px = (((hi >> bitn) & 1) << 1) | ((lo >> bitn) & 1);
			old = (k < objn) ? objq[k] : 0;
			if (sprs[i].attr[ATTR_PAL])
				px |= 4;
			if (sprs[i].attr[ATTR_BEHIND])
				px |= 8;
			objq[k] = (old & 3) ? old : px;
		end
		objn = 8;
	endfunction

	function automatic void fetch_tile_no();
		int wx, wy, adr, base, sx, sy;
		bit reach;
		wx = int'(winpos[7:0]);
		wy = int'(winpos[15:8]);
		reach = (fcol + 14) >= wx;
		if (lcdc[LCDC_WIN_ON] && lines >= wy && reach)
			win_on = 1;
		if (win_on && reach) begin
			base = lcdc[LCDC_WIN_MAP] ? int'(MAP_HI) : int'(MAP_LO);
			adr = base + ((wline & 255) >> 3) * 32 + ((fcol + 14 - wx) >> 3);
			l_row = wline & 7;
		end else begin
			base = lcdc[LCDC_BG_MAP] ? int'(MAP_HI) : int'(MAP_LO);
			sx = (lsx + fcol) & 255;
			sy = (int'(scroll[15:8]) + lines) & 255;
			adr = base + (sy >> 3) * 32 + (sx >> 3);
			l_row = sy & 7;
		end
		l_tile = vram_at(adr);
	endfunction

	function automatic int tile_row_addr();
		int off;
		off = l_tile * 16;
		if (!lcdc[LCDC_UNSIGN] && l_tile < 128)
			off += int'(TILE_SHIFT);
		return off + l_row * 2;
	endfunction

	function automatic void step_fetcher();
		if (!fphase) begin
			fphase = 1;
			return;
		end
		fphase = 0;
		case (fstep)
			0: begin fetch_tile_no(); fstep = 1; end
			1: begin l_lo = vram_at(tile_row_addr()); fstep = 2; end
			2: begin l_hi = vram_at(tile_row_addr() + 1); fstep = 3; end
			default: begin
				if (bgn <= 8) begin
					for (int b = 7; b >= 0; b--)
						bgq[bgn++] = (((l_hi >> b) & 1) << 1) | ((l_lo >> b) & 1);
					fcol = (fcol + 8) & 255;
					fstep = 0;
				end
			end
		endcase
	endfunction

	function automatic int pop_sprite_px();
		int v;
		if (objn == 0)
			return 0;
		v = objq[0];
		for (int k = 0; k < 7; k++)
			objq[k] = objq[k + 1];
		objn--;
		return v;
	endfunction

	function automatic bit mix_pixel(output int x, output int sh);
		int c, s, sp, pal;
		bit had;
		x = 0;
		sh = 0;
		if (bgn == 0)
			return 0;
		c = bgq[0];
		for (int k = 0; k < 15; k++)
			bgq[k] = bgq[k + 1];
		bgn--;
		// Fine horizontal scroll drops the first pixels of the line.
		if (ndisc < (lsx & 7)) begin
			void'(pop_sprite_px());
			ndisc++;
			return 0;
		end
		s = (int'(bgp) >> (c * 2)) & 3;
		had = objn != 0;
		sp = pop_sprite_px();
		if (had && (sp & 3) && (!(sp & 8) || c == 0)) begin
			pal = (sp & 4) ? int'(obp[15:8]) : int'(obp[7:0]);
			s = (pal >> ((sp & 3) * 2)) & 3;
		end
		x = dcol;
		sh = s;
		dcol++;
		if (win_on && dcol == SCREEN_WIDTH)
			wline = (wline + 1) & 255;
		return 1;
	endfunction

	function automatic bit dot_tick(output int x, output int sh);
		bit valid;
		valid = 0;
		x = 0;
		sh = 0;
		if (!lcdc[LCDC_ENABLE])
			return 0;
		if (lines >= VBLANK_LINE) begin
			if (dots == 0) begin
				if (lines == VBLANK_LINE)
					p_vb = 1;
				set_mode(MODE_VBLANK);
			end
		end else begin
			if (dots == 0) begin
				fstep = 0; fphase = 0; fcol = 0; dcol = 0; bgn = 0; objn = 0;
				nspr = 0; fetched = 0; lsx = int'(scroll[7:0]); ndisc = 0;
				set_mode(MODE_SCAN);
			end
			if (dots < SCAN_DOTS) begin
				scan_sprite();
			end else if (dots == SCAN_DOTS) begin
				set_mode(MODE_DRAW);
				sort_by_x();
			end else if (dcol < SCREEN_WIDTH) begin
				if (lcdc[LCDC_OBJ_ON]) begin
					for (int i = 0; i < nspr; i++) begin
						if (!fetched[i] && sprs[i].x == dcol) begin
							load_sprite_row(i);
							fetched[i] = 1'b1;
						end
					end
				end
				step_fetcher();
				valid = mix_pixel(x, sh);
			end else if (dcol == SCREEN_WIDTH) begin
				set_mode(MODE_HBLANK);
				dcol++;
			end
		end
		dots++;
		if (dots >= LINE_DOTS)
			next_line();
		return valid;
	endfunction

	function automatic ppu_word_t predict_pixel(logic [1:0] act, logic [12:0] adr,
			logic [7:0] dat);
		ppu_word_t w;
		int x, sh;
		bit valid;
		p_vb = 0; p_st = 0; p_fr = 0;
		valid = 0; x = 0; sh = 0;
		case (act)
			ACT_TICK: valid = dot_tick(x, sh);
			ACT_VRAM: vram_m[adr] = dat;
			ACT_OAM:  if (adr < OAM_BYTES) oam_m[adr] = dat;
			default: ;
		endcase
		w.valid = valid;
		w.x = valid ? 8'(x) : 8'd0;
		w.y = valid ? 8'(lines) : 8'd0;
		w.shade = valid ? 2'(sh) : 2'd0;
		w.mode = (mode_m == MODE_UNSET) ? 2'd0 : 2'(mode_m);
		w.coinc = coinc;
		w.vblank = p_vb;
		w.stat = p_st;
		w.frame = p_fr;
		return w;
	endfunction

	function automatic void add_row(bit is_cfg, logic [2:0] sel, logic [12:0] adr,
			logic [15:0] val, bit known, logic [24:0] want);
		dir_row_t r;
		r.is_cfg = is_cfg;
		r.sel = sel;
		r.adr = adr;
		r.val = val;
		r.known = known;
		r.want = want;
		rows.insert(rows.size(), r);
	endfunction

	task automatic report(string what, int got, int want);
		errors++;
		if (errors <= 40)
			$display("mismatch at word %0d: %s got %0d expected %0d", words_out, what, got, want);
	endtask

	task automatic check_word(logic [31:0] d);
		ppu_word_t e, g;
		if (pixel_q.size() == 0) begin
			report("word with nothing expected", int'(d), 0);
			return;
		end
		e = pixel_q.pop_front();
		g = d[24:0];
		if (d[31:25] !== '0) report("pad bits", int'(d[31:25]), 0);
		if (g.valid !== e.valid) report("pixel_valid", g.valid, e.valid);
		if (g.x !== e.x) report("pixel_x", g.x, e.x);
		if (g.y !== e.y) report("pixel_y", g.y, e.y);
		if (g.shade !== e.shade) report("shade", g.shade, e.shade);
		if (g.mode !== e.mode) report("lcd_mode", g.mode, e.mode);
		if (g.coinc !== e.coinc) report("coincidence", g.coinc, e.coinc);
		if (g.vblank !== e.vblank) report("vblank_irq", g.vblank, e.vblank);
		if (g.stat !== e.stat) report("stat_irq", g.stat, e.stat);
		if (g.frame !== e.frame) report("frame_done", g.frame, e.frame);
	endtask

	// Receiver: checks each word and, once, holds off long enough to back up the block.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_word(m_axis_tdata);
				words_out++;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!held && words_out >= HOLD_AT) begin
				held = 1;
				hold_left = HOLD_LEN;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic put_item(logic [1:0] act, logic [12:0] adr, logic [7:0] dat,
			bit known = 0, logic [24:0] want = '0);
		ppu_word_t w;
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, dat, adr, act};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		w = predict_pixel(act, adr, dat);
		pixel_q.insert(pixel_q.size(), known ? ppu_word_t'(want) : w);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		model_config(idx, v);
		@(posedge clk);
	endtask

	task automatic write_all(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
			logic [15:0] c3, logic [15:0] c4, logic [15:0] c5, logic [15:0] c6);
		drain();
		write_reg(CFG_LCDC, c0);
		write_reg(CFG_SCROLL, c1);
		write_reg(CFG_WINPOS, c2);
		write_reg(CFG_BGP, c3);
		write_reg(CFG_OBP, c4);
		write_reg(CFG_LYC, c5);
		write_reg(CFG_STATEN, c6);
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if (r < 86)
			put_item(ACT_TICK, 13'($urandom), 8'($urandom));
		else if (r < 93)
			put_item(ACT_VRAM, 13'($urandom), 8'($urandom));
		else if (r < 99)
			put_item(ACT_OAM, ($urandom_range(3) == 0) ? 13'($urandom) :
				13'($urandom_range(OAM_BYTES - 1)), 8'($urandom));
		else
			put_item(ACT_NONE, 13'($urandom), 8'($urandom));
	endtask

	initial begin
		logic [24:0] scan_word;
		logic [7:0] b;
		scan_word = 25'(MODE_SCAN) << 19;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		model_reset();

		// Every RAM byte gets written before any fetch can read it.
		for (int a = 0; a < VRAM_BYTES; a++)
			put_item(ACT_VRAM, 13'(a), 8'($urandom), 1, '0);
		for (int a = 0; a < OAM_BYTES; a++) begin
			case (a % 4)
				0: b = ((a / 4) % 3 == 0) ? 8'($urandom) : 8'($urandom_range(10, 24));
				1: b = ((a / 4) % 4 == 0) ? 8'(8 * $urandom_range(1, 4)) : 8'($urandom);
				default: b = 8'($urandom);
			endcase
			put_item(ACT_OAM, 13'(a), b, 1, '0);
		end

		add_row(0, 3'(ACT_VRAM), 13'd0, 16'h0000, 1, '0);
		add_row(0, 3'(ACT_VRAM), 13'h1FFF, 16'h00FF, 1, '0);
		add_row(0, 3'(ACT_OAM), 13'd159, 16'h00FF, 1, '0);
		add_row(0, 3'(ACT_OAM), 13'd160, 16'h00AA, 1, '0);
		add_row(0, 3'(ACT_OAM), 13'h1FFF, 16'h0055, 1, '0);
		add_row(0, 3'(ACT_NONE), 13'h1FFF, 16'h00FF, 1, '0);
		add_row(0, 3'(ACT_TICK), 13'd0, 16'h0000, 1, scan_word);
		// With the display off a tick must leave everything as it was.
		add_row(1, CFG_LCDC, 13'd0, 16'h0011, 0, '0);
		add_row(0, 3'(ACT_TICK), 13'h1555, 16'h00AA, 1, scan_word);
		add_row(0, 3'(ACT_TICK), 13'h0AAA, 16'h0055, 1, scan_word);
		add_row(1, CFG_LCDC, 13'd0, 16'h0093, 0, '0);
		add_row(1, CFG_STATEN, 13'd0, 16'h000F, 0, '0);
		for (int i = 0; i < 10; i++)
			add_row(0, 3'(ACT_TICK), 13'd0, 16'h0000, 0, '0);
		add_row(0, 3'(ACT_VRAM), 13'h1800, 16'h0080, 0, '0);
		add_row(0, 3'(ACT_TICK), 13'd0, 16'h0000, 0, '0);
		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				drain();
				write_reg(rows[i].sel, rows[i].val);
			end else begin
				put_item(rows[i].sel[1:0], rows[i].adr, rows[i].val[7:0],
					rows[i].known, rows[i].want);
			end
		end

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: write_all(16'h0093, 16'h0000, 16'h0000, 16'h00E4, 16'h1BE4, 16'h0000, 16'h000F);
				1: write_all(16'h00FF, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF, 16'h00FF, 16'h000F);
				2: write_all(16'h00F7, 16'($urandom), 16'($urandom), 16'($urandom_range(255)),
					16'($urandom), 16'($urandom_range(255)), 16'($urandom_range(15)));
				3: write_all(16'h00E3, 16'h0203, 16'h0007, 16'h0027, 16'h9C63, 16'h0003, 16'h0000);
				default: write_all(16'h0080 | 16'($urandom_range(127)), 16'($urandom),
					16'($urandom), 16'($urandom_range(255)), 16'($urandom),
					16'($urandom_range(255)), 16'($urandom_range(15)));
			endcase
			calm = (p == 3);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_item();
		end
		calm = 0;

		drain();
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
